>>> rtl/lfpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line follower PID drive block.
// Used by lfpd_ctrl, lfpd_datapath and line_follow_pid_drive; no dependencies.
package lfpd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_PWM   = 255;
	localparam int GAIN_FRAC = 12;
	localparam int Q_SHIFT   = FRAC_BITS - GAIN_FRAC;
	localparam int ONE_Q     = 1 << FRAC_BITS;
	localparam int DECAY_RAW = ((ONE_Q + 500) / 1000 > 0) ? (ONE_Q + 500) / 1000 : 1;

	// Working width for term sums, wide enough for every pre-clamp sum.
	localparam int SUM_W  = FRAC_BITS + 11;
	localparam int INT_W  = FRAC_BITS + 2;
	localparam int DER_W  = FRAC_BITS + 4;
	localparam int PID_W  = FRAC_BITS + 2;
	localparam int PROD_W = 20;

	localparam int DIV_STEPS = 8;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		CFG_GAIN_P     = 3'd0,
		CFG_GAIN_I     = 3'd1,
		CFG_GAIN_D     = 3'd2,
		CFG_INVERT_FWD = 3'd3,
		CFG_SET_POINT  = 3'd4,
		CFG_BASE_SPEED = 3'd5,
		CFG_SOFT_START = 3'd6
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P,
		ST_I,
		ST_D,
		ST_SUM,
		ST_DIV,
		ST_RED,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic calc_p;
		logic calc_i;
		logic calc_d;
		logic calc_sum;
		logic div_step;
		logic calc_red;
		logic drive_out;
	} cmd_t;

	typedef struct packed {
		logic halt;
		logic out_free;
	} status_t;

	function automatic logic signed [SUM_W-1:0] clamp_sym(
		input logic signed [SUM_W-1:0] v,
		input logic signed [SUM_W-1:0] lim
	);
		logic signed [SUM_W-1:0] r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/lfpd_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the line follower PID drive block.
// Depends on lfpd_pkg for the state type and the command and status structs.
module lfpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lfpd_pkg::status_t status,
	output lfpd_pkg::cmd_t    cmd
);

	lfpd_pkg::state_t state_q, state_next;
	logic [lfpd_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfpd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == lfpd_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lfpd_pkg::ST_IDLE: if (in_valid) state_next = lfpd_pkg::ST_P;
			lfpd_pkg::ST_P: begin
				// A halted tick skips the rest of the control computation.
				state_next = status.halt ? lfpd_pkg::ST_OUT : lfpd_pkg::ST_I;
			end
			lfpd_pkg::ST_I:   state_next = lfpd_pkg::ST_D;
			lfpd_pkg::ST_D:   state_next = lfpd_pkg::ST_SUM;
			lfpd_pkg::ST_SUM: state_next = lfpd_pkg::ST_DIV;
			lfpd_pkg::ST_DIV: begin
				if (cnt_q == lfpd_pkg::CNT_W'(lfpd_pkg::DIV_STEPS - 1)) begin
					state_next = lfpd_pkg::ST_RED;
				end
			end
			lfpd_pkg::ST_RED: state_next = lfpd_pkg::ST_OUT;
			lfpd_pkg::ST_OUT: if (status.out_free) state_next = lfpd_pkg::ST_IDLE;
			default:          state_next = lfpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			lfpd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lfpd_pkg::ST_P:    cmd.calc_p    = 1'b1;
			lfpd_pkg::ST_I:    cmd.calc_i    = 1'b1;
			lfpd_pkg::ST_D:    cmd.calc_d    = 1'b1;
			lfpd_pkg::ST_SUM:  cmd.calc_sum  = 1'b1;
			lfpd_pkg::ST_DIV:  cmd.div_step  = 1'b1;
			lfpd_pkg::ST_RED:  cmd.calc_red  = 1'b1;
			lfpd_pkg::ST_OUT:  cmd.drive_out = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/lfpd_datapath.sv
`timescale 1ns / 1ps
// Datapath for the line follower PID drive block: configuration registers,
// PID state, ramp divider, steering and the output register. Uses lfpd_pkg.
module lfpd_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    sensor_left,
	input  logic                    sensor_right,
	input  logic [15:0]             elapsed_ms,
	input  logic                    halt,
	input  lfpd_pkg::cmd_t          cmd,
	output lfpd_pkg::status_t       status,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [8:0]       left_pwm,
	output logic signed [8:0]       right_pwm,
	output logic [2:0]              line_position
);

	localparam int SW = lfpd_pkg::SUM_W;
	localparam logic signed [SW-1:0] LIM_ONE  = SW'(lfpd_pkg::ONE_Q);
	localparam logic signed [SW-1:0] LIM_FOUR = SW'(4 * lfpd_pkg::ONE_Q);
	localparam logic signed [lfpd_pkg::DER_W-1:0] DECAY =
		lfpd_pkg::DER_W'(lfpd_pkg::DECAY_RAW);

	// Configuration registers.
	logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;
	logic               invert_q;
	logic [2:0]         set_point_q;
	logic [7:0]         base_q;
	logic [15:0]        soft_q;

	// PID state.
	logic signed [lfpd_pkg::INT_W-1:0] integral_q;
	logic signed [lfpd_pkg::DER_W-1:0] deriv_q;
	logic signed [3:0]                 prev_err_q;
	logic [2:0]                        last_side_q;

	// Per-tick working registers.
	logic [2:0]                         pos_q;
	logic                               halt_q;
	logic [15:0]                        elapsed_q;
	logic signed [3:0]                  err_q;
	logic signed [lfpd_pkg::PROD_W-1:0] p_q;
	logic [23:0]                        num_q;
	logic signed [lfpd_pkg::PID_W-1:0]  pid_q;
	logic [15:0]                        rem_q;
	logic [7:0]                         quo_q;
	logic                               ramp_q;
	logic [7:0]                         speed_q;
	logic [7:0]                         red_q;
	logic                               out_valid_q;

	logic [2:0]                         pos;
	logic [3:0]                         err_w;
	logic signed [lfpd_pkg::PROD_W-1:0] p_prod, i_prod;
	logic signed [4:0]                  d_err;
	logic signed [20:0]                 d_prod;
	logic signed [SW-1:0]               i_sum, d_sum, d_clamp, pid_sum;
	logic signed [lfpd_pkg::DER_W-1:0]  d_sat, d_decayed;
	logic [17:0]                        trial;
	logic [7:0]                         speed;
	logic [16:0]                        mag;
	logic [24:0]                        red_prod;
	logic [7:0]                         lw, rw;

	always_comb begin
		unique case ({sensor_left, sensor_right})
			2'b00:   pos = 3'd3;
			2'b01:   pos = 3'd2;
			2'b10:   pos = 3'd4;
			default: pos = last_side_q;
		endcase
	end

	assign err_w  = 4'({1'b0, pos}) - 4'({1'b0, set_point_q});
	assign p_prod = lfpd_pkg::PROD_W'(gain_p_q) * lfpd_pkg::PROD_W'(err_q);
	assign i_prod = lfpd_pkg::PROD_W'(gain_i_q) * lfpd_pkg::PROD_W'(err_q);
	assign d_err  = 5'(err_q) - 5'(prev_err_q);
	assign d_prod = 21'(gain_d_q) * 21'(d_err);

	assign i_sum = SW'(integral_q) + (SW'(i_prod) <<< lfpd_pkg::Q_SHIFT);
	assign d_sum = SW'(deriv_q) + (SW'(d_prod) <<< lfpd_pkg::Q_SHIFT);
	assign d_clamp = lfpd_pkg::clamp_sym(d_sum, LIM_FOUR);
	assign d_sat   = d_clamp[lfpd_pkg::DER_W-1:0];

	// The derivative decays toward zero and never crosses it.
	always_comb begin
		if (d_sat > DECAY) begin
			d_decayed = d_sat - DECAY;
		end else if (d_sat < -DECAY) begin
			d_decayed = d_sat + DECAY;
		end else begin
			d_decayed = '0;
		end
	end

	assign pid_sum = (SW'(p_q) <<< lfpd_pkg::Q_SHIFT) + SW'(integral_q) + SW'(deriv_q);

	// One restoring division step on the remainder and shifting quotient.
	assign trial = {1'b0, rem_q, quo_q[7]} - {2'b00, soft_q};

	assign speed    = ramp_q ? quo_q : base_q;
	assign mag      = pid_q[lfpd_pkg::PID_W-1] ? 17'(-pid_q) : 17'(pid_q);
	assign red_prod = 25'(mag) * 25'(speed);

	assign lw = (!pid_q[lfpd_pkg::PID_W-1] && pid_q != '0) ? speed_q - red_q : speed_q;
	assign rw = pid_q[lfpd_pkg::PID_W-1] ? speed_q - red_q : speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			invert_q    <= 1'b0;
			set_point_q <= 3'd3;
			base_q      <= '0;
			soft_q      <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lfpd_pkg::CFG_GAIN_P:     gain_p_q    <= cfg_data;
				lfpd_pkg::CFG_GAIN_I:     gain_i_q    <= cfg_data;
				lfpd_pkg::CFG_GAIN_D:     gain_d_q    <= cfg_data;
				lfpd_pkg::CFG_INVERT_FWD: invert_q    <= cfg_data[0];
				lfpd_pkg::CFG_SET_POINT:  set_point_q <= cfg_data[2:0];
				lfpd_pkg::CFG_BASE_SPEED: base_q      <= cfg_data[7:0];
				lfpd_pkg::CFG_SOFT_START: soft_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			deriv_q     <= '0;
			prev_err_q  <= '0;
			last_side_q <= 3'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (halt) begin
					integral_q <= '0;
					deriv_q    <= '0;
					prev_err_q <= '0;
				end else if (!sensor_left && sensor_right) begin
					last_side_q <= 3'd1;
				end else if (sensor_left && !sensor_right) begin
					last_side_q <= 3'd5;
				end
			end
			if (cmd.calc_i) begin
				integral_q <= lfpd_pkg::INT_W'(lfpd_pkg::clamp_sym(i_sum, LIM_ONE));
			end
			if (cmd.calc_d) begin
				deriv_q    <= d_decayed;
				prev_err_q <= err_q;
			end
			if (cmd.drive_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q     <= pos;
			halt_q    <= halt;
			elapsed_q <= elapsed_ms;
			err_q     <= err_w;
		end
		if (cmd.calc_p) begin
			p_q   <= p_prod;
			num_q <= 24'(base_q) * 24'(elapsed_q);
		end
		if (cmd.calc_sum) begin
			pid_q  <= lfpd_pkg::PID_W'(lfpd_pkg::clamp_sym(pid_sum, LIM_ONE));
			rem_q  <= num_q[23:8];
			quo_q  <= num_q[7:0];
			ramp_q <= elapsed_q < soft_q;
		end
		if (cmd.div_step) begin
			if (!trial[17]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[7]};
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
		if (cmd.calc_red) begin
			speed_q <= speed;
			red_q   <= red_prod[23:16];
		end
		if (cmd.drive_out) begin
			line_position <= pos_q;
			if (halt_q) begin
				left_pwm  <= '0;
				right_pwm <= '0;
			end else if (invert_q) begin
				left_pwm  <= $signed({1'b0, lw});
				right_pwm <= -$signed({1'b0, rw});
			end else begin
				left_pwm  <= -$signed({1'b0, lw});
				right_pwm <= $signed({1'b0, rw});
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status.halt     = halt_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

>>> rtl/line_follow_pid_drive.sv
`timescale 1ns / 1ps
// Line follower PID drive: a tick runs acceptance, three term updates, pid
// sum, 8 ramp-division steps of a one-bit-per-cycle restoring divider,
// steering multiply and an output load that waits for a free output register;
// a halted tick skips from P to the output load. A finished beat waits in
// the output register. Reset clears the PID state, sets last side to right
// and loads the register defaults; the configuration port is always ready.
module line_follow_pid_drive (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              sensor_left,
	input  logic              sensor_right,
	input  logic [15:0]       elapsed_ms,
	input  logic              halt,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [8:0] left_pwm,
	output logic signed [8:0] right_pwm,
	output logic [2:0]        line_position
);

	lfpd_pkg::cmd_t    cmd;
	lfpd_pkg::status_t status;

	assign cfg_ready = 1'b1;

	lfpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lfpd_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sensor_left   (sensor_left),
		.sensor_right  (sensor_right),
		.elapsed_ms    (elapsed_ms),
		.halt          (halt),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_pwm      (left_pwm),
		.right_pwm     (right_pwm),
		.line_position (line_position)
	);

endmodule
